>>> rtl/core/ecmp_pkg.sv
// Shared constants and types for the equal-cost path selector.
`default_nettype none

package ecmp_pkg;

    localparam int unsigned DIV_W         = 32;
    localparam int unsigned MAX_PATHS_DEF = 65535;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned INDEX_W       = 16;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam logic [31:0] WEIGHT_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] HASH_SPACE  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        SEL_OFF    = 2'd0,
        SEL_THRESH = 2'd1,
        SEL_HRW    = 2'd2,
        SEL_MOD    = 2'd3
    } t_sel_mode;

endpackage

`default_nettype wire

>>> rtl/core/ecmp_div.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
`default_nettype none

module ecmp_div #(
    parameter int unsigned W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient,
    output logic [W-1:0]      o_remainder
);

    localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        fits   = ~diff[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor whenever the divisor is nonzero.
                r_rem <= fits ? diff[W-1:0] : rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/ecmp_path_select_top.sv
// An accepted word goes straight to the result when disabled or with a zero path count;
// modulo-n runs one division, hash threshold runs two divisions, and highest random
// weight scores the paths with one shared LCG multiplier, one path per cycle. One word is
// in work at a time; with the output free the next word is taken in the same cycle as the
// result appears. Reset (synchronous, active low) empties the block and sets the mode to
// highest random weight.
`default_nettype none

module ecmp_path_select_top #(
    parameter int unsigned MAX_PATHS = ecmp_pkg::MAX_PATHS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_wr_data,  // select_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] flow_hash, [47:32] path_count
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [15:0] path_index
);

    import ecmp_pkg::*;

    localparam int unsigned IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS + 1) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_HRW_INIT,
        S_HRW,
        S_DONE
    } t_state;

    t_state               r_state;
    t_sel_mode            r_mode;
    logic [KEY_W-1:0]     r_key;
    logic [IDX_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_i;
    logic [31:0]          r_t0;
    logic [31:0]          r_w;
    logic [IDX_W-1:0]     r_w_idx;
    logic                 r_w_vld;
    logic [31:0]          r_best_w;
    logic [IDX_W-1:0]     r_best;
    logic [INDEX_W-1:0]   r_res;
    logic                 r_div_go;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_dvs;
    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_out_data;

    logic [KEY_W-1:0]     in_key;
    logic [COUNT_W-1:0]   in_cnt;
    logic [COUNT_W-1:0]   sat_cnt;
    logic                 accept;
    logic [31:0]          mul_a;
    logic [31:0]          mul_y;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [DIV_W-1:0]     div_rem;
    logic                 out_free;

    assign in_key   = s_axis_tdata[31:0];
    assign in_cnt   = s_axis_tdata[47:32];
    assign sat_cnt  = (in_cnt > COUNT_W'(MAX_PATHS)) ? COUNT_W'(MAX_PATHS) : in_cnt;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Shared LCG step: seeds the weight chain once, then scores each path index.
    always_comb begin
        mul_a = (r_state == S_HRW_INIT) ? (r_key & WEIGHT_MASK) : (r_t0 ^ 32'(r_i));
        mul_y = (LCG_MUL * mul_a) + LCG_ADD;
    end

    ecmp_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_go),
        .i_dividend  (r_dvd),
        .i_divisor   (r_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= SEL_HRW;
            r_div_go    <= 1'b0;
            r_w_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;

            if (i_cfg_wr_en) begin
                r_mode <= t_sel_mode'(i_cfg_wr_data);
            end

            // The best weight tracker works on the registered weight, in the cycle after the multiplier scored it.
            if (r_w_vld && ((r_w_idx == '0) || (r_w > r_best_w))) begin
                r_best_w <= r_w;
                r_best   <= r_w_idx;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= (r_mode == SEL_HRW && r_cnt != '0) ? INDEX_W'(r_best) : r_res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key <= in_key;
                        r_cnt <= IDX_W'(sat_cnt);
                        r_res <= '0;
                        if (sat_cnt == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            unique case (r_mode)
                                SEL_OFF: begin
                                    r_state <= S_DONE;
                                end
                                SEL_THRESH: begin
                                    r_dvd    <= HASH_SPACE;
                                    r_dvs    <= DIV_W'(sat_cnt);
                                    r_div_go <= 1'b1;
                                    r_state  <= S_DIV1;
                                end
                                SEL_HRW: begin
                                    r_state <= S_HRW_INIT;
                                end
                                SEL_MOD: begin
                                    r_dvd    <= in_key;
                                    r_dvs    <= DIV_W'(sat_cnt);
                                    r_div_go <= 1'b1;
                                    r_state  <= S_DIV1;
                                end
                                default: begin
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        if (r_mode == SEL_MOD) begin
                            r_res   <= INDEX_W'(div_rem);
                            r_state <= S_DONE;
                        end else begin
                            // The region width is never zero for a count below 2^16.
                            r_dvd    <= r_key;
                            r_dvs    <= div_quo;
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        if (div_quo >= DIV_W'(r_cnt)) begin
                            r_res <= INDEX_W'(r_cnt - 1'b1);
                        end else begin
                            r_res <= INDEX_W'(div_quo);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_HRW_INIT: begin
                    r_t0    <= mul_y;
                    r_i     <= '0;
                    r_state <= S_HRW;
                end
                S_HRW: begin
                    if (r_i != r_cnt) begin
                        r_w     <= mul_y & WEIGHT_MASK;
                        r_w_idx <= r_i;
                        r_w_vld <= 1'b1;
                        r_i     <= r_i + 1'b1;
                    end else begin
                        // The last weight is compared at this edge.
                        r_w_vld <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> dv/ecmp_path_select_checker.sv
// Checker for the equal-cost path selector: predicts each path index and compares results.
`timescale 1ns / 100ps

module ecmp_path_select_checker
    import ecmp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_wr_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [47:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);

    t_sel_mode   mode_q;
    logic [15:0] path_index_q[$];
    int          err_cnt = 0;

    function automatic logic [31:0] lcg_weight(input logic [31:0] key, input logic [31:0] idx);
        logic [31:0] t;
        t = LCG_MUL * (key & WEIGHT_MASK) + LCG_ADD;
        t = t ^ idx;
        t = LCG_MUL * t + LCG_ADD;
        return t & WEIGHT_MASK;
    endfunction

    function automatic logic [15:0] predict_path_index(input t_sel_mode mode,
                                                       input logic [31:0] key,
                                                       input logic [15:0] count);
        logic [31:0] region;
        logic [31:0] quot;
        logic [31:0] best_w;
        logic [31:0] w;
        logic [15:0] best;
        if (count == 16'd0) begin
            return 16'd0;
        end
        case (mode)
            SEL_THRESH: begin
                region = HASH_SPACE / {16'd0, count};
                quot   = key / region;
                // The top region can overshoot by one; it folds onto the last path.
                return (quot >= {16'd0, count}) ? count - 16'd1 : quot[15:0];
            end
            SEL_HRW: begin
                best   = 16'd0;
                best_w = lcg_weight(key, 32'd0);
                for (int unsigned n = 1; n < count; n++) begin
                    w = lcg_weight(key, n);
                    if (w > best_w) begin
                        best_w = w;
                        best   = n[15:0];
                    end
                end
                return best;
            end
            SEL_MOD: begin
                quot = key % {16'd0, count};
                return quot[15:0];
            end
            default: begin
                return 16'd0;
            end
        endcase
    endfunction

    task automatic flag_error(input string what, input logic [15:0] want, input logic [15:0] got);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s: expected path_index %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            mode_q <= SEL_HRW;
            path_index_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                mode_q <= t_sel_mode'(i_cfg_wr_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                path_index_q.push_back(predict_path_index(mode_q, i_s_tdata[31:0],
                                                          i_s_tdata[47:32]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (path_index_q.size() == 0) begin
                    flag_error("result word with nothing pending", 16'd0, i_m_tdata);
                end else begin
                    want = path_index_q.pop_front();
                    if (i_m_tdata !== want) begin
                        flag_error("path_index mismatch", want, i_m_tdata);
                    end
                end
            end
            o_pending <= path_index_q.size();
        end
        o_errors <= err_cnt;
    end

endmodule

>>> dv/tb_ecmp_path_select_top.sv
// Testbench top for the equal-cost path selector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_ecmp_path_select_top;
    import ecmp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int NUM_PROBES  = 20;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 60;

    typedef struct packed {
        t_sel_mode   mode;
        logic [31:0] hash;
        logic [15:0] count;
    } t_probe;

    // Hand-picked words: zero and maximum counts, saturated hashes, the masked
    // top hash bit in rendezvous scoring and the hash-threshold clamp.
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{SEL_HRW,    32'h0000_0000, 16'd0},
        '{SEL_HRW,    32'hFFFF_FFFF, 16'd1},
        '{SEL_HRW,    32'h8000_0000, 16'd2},
        '{SEL_HRW,    32'h0000_0000, 16'd2},
        '{SEL_HRW,    32'hFFFF_FFFF, 16'd65535},
        '{SEL_HRW,    32'h1234_5678, 16'd16},
        '{SEL_OFF,    32'hFFFF_FFFF, 16'd65535},
        '{SEL_OFF,    32'h5A5A_5A5A, 16'd9},
        '{SEL_OFF,    32'h0000_0000, 16'd0},
        '{SEL_THRESH, 32'hFFFF_FFFF, 16'd1},
        '{SEL_THRESH, 32'hFFFF_FFFF, 16'd3},
        '{SEL_THRESH, 32'hFFFF_FFFF, 16'd65535},
        '{SEL_THRESH, 32'h0000_0000, 16'd7},
        '{SEL_THRESH, 32'h7FFF_FFFF, 16'd2},
        '{SEL_THRESH, 32'hDEAD_BEEF, 16'd0},
        '{SEL_MOD,    32'hFFFF_FFFF, 16'd65535},
        '{SEL_MOD,    32'hFFFF_FFFF, 16'd1},
        '{SEL_MOD,    32'd123456789, 16'd1000},
        '{SEL_MOD,    32'h0000_0000, 16'd0},
        '{SEL_MOD,    32'h8000_0000, 16'd3}
    };

    localparam t_sel_mode PHASE_MODES [NUM_PHASES] = '{
        SEL_THRESH, SEL_HRW, SEL_MOD, SEL_OFF, SEL_HRW, SEL_THRESH, SEL_MOD, SEL_HRW
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_wr_data = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = 48'd0;
    logic        m_axis_tready = 1'b0;
    wire logic   s_axis_tready;
    wire logic   m_axis_tvalid;
    wire logic [15:0] m_axis_tdata;

    int        errors;
    int        pending;
    int        cycles  = 0;
    bit        idle_en = 1'b1;
    t_sel_mode cur_mode = SEL_HRW;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ecmp_path_select_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ecmp_path_select_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= !idle_en || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic [31:0] hash, input logic [15:0] count);
        while (idle_en && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, hash};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds the input off until every predicted word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apply_mode(input t_sel_mode mode);
        if (mode != cur_mode) begin
            drain();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= mode;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            cur_mode = mode;
        end
    endtask

    function automatic logic [31:0] rand_hash();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 32'h0000_0000;
        end else if (r < 10) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // Rendezvous scoring handles one path per cycle, so its counts stay modest;
    // the other modes take counts from the whole range.
    function automatic logic [15:0] rand_count(input t_sel_mode mode);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 16'd0;
        end
        if (mode == SEL_HRW) begin
            if (r < 80) begin
                return 16'($urandom_range(16, 1));
            end else if (r < 96) begin
                return 16'($urandom_range(255, 17));
            end
            return 16'($urandom_range(1023, 256));
        end
        if (r < 45) begin
            return 16'($urandom_range(65535, 0));
        end
        return 16'($urandom_range(64, 1));
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PROBES; p++) begin
            apply_mode(PROBES[p].mode);
            send_word(PROBES[p].hash, PROBES[p].count);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_mode(PHASE_MODES[ph]);
            idle_en = (ph != 4);
            repeat (PHASE_WORDS) begin
                send_word(rand_hash(), rand_count(cur_mode));
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> ecmp_path_select_top.f
rtl/core/ecmp_pkg.sv
rtl/core/ecmp_div.sv
rtl/core/ecmp_path_select_top.sv
dv/ecmp_path_select_checker.sv
dv/tb_ecmp_path_select_top.sv
